/* rtl/tpmc_pkg.sv */
// ----------------------------------------------------------------------------
// tpmc_pkg
// Shared types, codes and constants for the tracker power mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tpmc_pkg;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 17;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Power modes
    localparam logic [1:0] MODE_ACTIVE  = 2'd0;
    localparam logic [1:0] MODE_STANDBY = 2'd1;
    localparam logic [1:0] MODE_SLEEP   = 2'd2;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    // Event kinds
    localparam logic [1:0] EV_PERIODIC = 2'd0;
    localparam logic [1:0] EV_MOTION   = 2'd1;
    localparam logic [1:0] EV_COMMAND  = 2'd2;
    localparam logic [1:0] EV_IGNITION = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_EN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANTI_THEFT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOLD  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [DELAY_W-1:0] SLEEP_DELAY_RST = 17'd300;
    localparam logic [HOLD_W-1:0]  ALARM_HOLD_RST  = 16'd300;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] now_sec;
        logic [1:0]        target_mode;
        logic              ignition_on;
        logic              raise_alarm;
    } t_in_item;

    typedef struct packed {
        logic [1:0] track_mode;
        logic       gps_power;
        logic       moving;
        logic       alarm_active;
        logic       mode_changed;
        logic       save_request;
        logic       clear_alarm_report;
        logic       clear_vibration;
        logic       theft_check;
    } t_out_item;

    typedef struct packed {
        logic [DELAY_W-1:0] sleep_delay_sec;
        logic               sleep_enable;
        logic               anti_theft_enable;
        logic [HOLD_W-1:0]  alarm_hold_sec;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        current_mode;
        logic              ignition_state;
        logic              ignition_off_pending;
        logic [TIME_W-1:0] ignition_off_time;
        logic              motion_state;
        logic [TIME_W-1:0] motion_time;
        logic              vibration_alarm;
        logic              theft_check_flag;
    } t_state;

endpackage

`default_nettype wire

/* rtl/tpmc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tpmc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmc_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tpmc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tpmc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tpmc_pkg::t_cfg                        o_cfg
);

    tpmc_pkg::t_cfg r_cfg;

    // Register writes, data masked to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sleep_delay_sec   <= tpmc_pkg::SLEEP_DELAY_RST;
            r_cfg.sleep_enable      <= 1'b1;
            r_cfg.anti_theft_enable <= 1'b0;
            r_cfg.alarm_hold_sec    <= tpmc_pkg::ALARM_HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tpmc_pkg::CFG_SLEEP_DELAY: begin
                    r_cfg.sleep_delay_sec <= i_cfg_data[tpmc_pkg::DELAY_W-1:0];
                end
                tpmc_pkg::CFG_SLEEP_EN: begin
                    r_cfg.sleep_enable <= i_cfg_data[0];
                end
                tpmc_pkg::CFG_ANTI_THEFT: begin
                    r_cfg.anti_theft_enable <= i_cfg_data[0];
                end
                tpmc_pkg::CFG_ALARM_HOLD: begin
                    r_cfg.alarm_hold_sec <= i_cfg_data[tpmc_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/tpmc_step.sv */
// ----------------------------------------------------------------------------
// tpmc_step
// Next-state and result logic for one event item.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmc_step (
    input  wire tpmc_pkg::t_cfg     i_cfg,
    input  wire tpmc_pkg::t_state   i_state,
    input  wire tpmc_pkg::t_in_item i_item,
    output tpmc_pkg::t_state        o_state,
    output tpmc_pkg::t_out_item     o_result
);

    logic [tpmc_pkg::TIME_W-1:0] now;
    logic [tpmc_pkg::TIME_W-1:0] motion_diff;
    logic [tpmc_pkg::TIME_W-1:0] ioff_diff;
    logic [tpmc_pkg::TIME_W-1:0] delay_ext;
    logic [tpmc_pkg::TIME_W-1:0] hold_ext;
    logic                        motion_behind;
    logic                        motion_elapsed;
    logic                        hold_elapsed;
    logic                        ioff_after;
    logic                        ioff_elapsed;

    tpmc_pkg::t_state n_st;
    logic             p_save;
    logic             p_report;
    logic             p_vib;
    logic             mt_now;
    logic             changed;

    // Shared time compares, all against the stored state
    assign now            = i_item.now_sec;
    assign delay_ext      = {{(tpmc_pkg::TIME_W-tpmc_pkg::DELAY_W){1'b0}}, i_cfg.sleep_delay_sec};
    assign hold_ext       = {{(tpmc_pkg::TIME_W-tpmc_pkg::HOLD_W){1'b0}}, i_cfg.alarm_hold_sec};
    assign motion_diff    = now - i_state.motion_time;
    assign ioff_diff      = now - i_state.ignition_off_time;
    assign motion_behind  = now < i_state.motion_time;
    assign motion_elapsed = motion_diff >= delay_ext;
    assign hold_elapsed   = motion_diff >= hold_ext;
    assign ioff_after     = now > i_state.ignition_off_time;
    assign ioff_elapsed   = ioff_diff >= delay_ext;

    // Event decode and state update
    always_comb begin
        n_st     = i_state;
        p_save   = 1'b0;
        p_report = 1'b0;
        p_vib    = 1'b0;
        mt_now   = 1'b0;
        case (i_item.mode)
            tpmc_pkg::EV_PERIODIC: begin
                // motion timeout; clock running backwards resyncs the mark
                if (i_state.motion_state) begin
                    if (motion_behind) begin
                        n_st.motion_time = now;
                        mt_now           = 1'b1;
                    end else if (motion_elapsed) begin
                        n_st.motion_time  = now;
                        n_st.motion_state = 1'b0;
                        p_save            = 1'b1;
                        mt_now            = 1'b1;
                    end
                end
                // alarm hold: a just-resynced mark gives zero elapsed time
                if (i_state.vibration_alarm &&
                    (mt_now ? (i_cfg.alarm_hold_sec == '0) : hold_elapsed)) begin
                    n_st.vibration_alarm = 1'b0;
                    p_save               = 1'b1;
                end
                // mode selection
                if (i_state.ignition_state) begin
                    n_st.current_mode = tpmc_pkg::MODE_ACTIVE;
                end else if (!i_cfg.sleep_enable) begin
                    n_st.current_mode = tpmc_pkg::MODE_STANDBY;
                end else if (i_state.ignition_off_pending) begin
                    if (i_state.current_mode != tpmc_pkg::MODE_STANDBY &&
                        i_state.current_mode != tpmc_pkg::MODE_SLEEP) begin
                        n_st.current_mode = tpmc_pkg::MODE_STANDBY;
                    end
                    if (ioff_after) begin
                        if (ioff_elapsed) begin
                            n_st.ignition_off_pending = 1'b0;
                            n_st.current_mode         = tpmc_pkg::MODE_SLEEP;
                        end
                    end else begin
                        n_st.ignition_off_time = now;
                    end
                end else if (n_st.motion_state) begin
                    n_st.current_mode = tpmc_pkg::MODE_STANDBY;
                end else begin
                    n_st.current_mode = tpmc_pkg::MODE_SLEEP;
                end
            end
            tpmc_pkg::EV_MOTION: begin
                n_st.motion_time  = now;
                n_st.motion_state = 1'b1;
                if (i_item.raise_alarm) begin
                    n_st.vibration_alarm = 1'b1;
                end
            end
            tpmc_pkg::EV_COMMAND: begin
                case (i_item.target_mode)
                    tpmc_pkg::MODE_ACTIVE: begin
                        if (i_state.current_mode != tpmc_pkg::MODE_ACTIVE) begin
                            n_st.motion_time          = now;
                            n_st.motion_state         = 1'b1;
                            n_st.ignition_state       = 1'b1;
                            n_st.ignition_off_pending = 1'b0;
                            n_st.theft_check_flag     = 1'b0;
                            n_st.current_mode         = tpmc_pkg::MODE_ACTIVE;
                            p_report                  = 1'b1;
                        end
                    end
                    tpmc_pkg::MODE_STANDBY: begin
                        if (i_state.current_mode != tpmc_pkg::MODE_STANDBY) begin
                            n_st.motion_time          = now;
                            n_st.motion_state         = 1'b1;
                            n_st.ignition_off_time    = now;
                            n_st.ignition_off_pending = 1'b1;
                            n_st.ignition_state       = 1'b0;
                            if (!i_cfg.anti_theft_enable) begin
                                n_st.theft_check_flag = 1'b1;
                            end
                            n_st.current_mode = tpmc_pkg::MODE_STANDBY;
                            p_report          = 1'b1;
                        end
                    end
                    tpmc_pkg::MODE_SLEEP: begin
                        if (i_state.current_mode != tpmc_pkg::MODE_SLEEP) begin
                            if (i_state.ignition_state) begin
                                n_st.ignition_state = 1'b0;
                                p_report            = 1'b1;
                            end
                            n_st.motion_time          = '0;
                            n_st.motion_state         = 1'b0;
                            n_st.ignition_off_time    = '0;
                            n_st.ignition_off_pending = 1'b0;
                            n_st.current_mode         = tpmc_pkg::MODE_SLEEP;
                            p_vib                     = 1'b1;
                        end
                    end
                    default: begin
                        // ignored target
                    end
                endcase
            end
            tpmc_pkg::EV_IGNITION: begin
                // level change only; same updates as a command, mode untouched
                if (i_item.ignition_on != i_state.ignition_state) begin
                    n_st.motion_time  = now;
                    n_st.motion_state = 1'b1;
                    if (i_item.ignition_on) begin
                        n_st.ignition_state       = 1'b1;
                        n_st.ignition_off_pending = 1'b0;
                        n_st.theft_check_flag     = 1'b0;
                    end else begin
                        n_st.ignition_off_time    = now;
                        n_st.ignition_off_pending = 1'b1;
                        n_st.ignition_state       = 1'b0;
                        if (!i_cfg.anti_theft_enable) begin
                            n_st.theft_check_flag = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result item built from the updated state
    assign changed = n_st.current_mode != i_state.current_mode;
    assign o_state = n_st;

    always_comb begin
        o_result.track_mode         = n_st.current_mode;
        o_result.gps_power          = n_st.current_mode != tpmc_pkg::MODE_SLEEP;
        o_result.moving             = n_st.motion_state;
        o_result.alarm_active       = n_st.vibration_alarm;
        o_result.mode_changed       = changed;
        o_result.save_request       = changed | p_save;
        o_result.clear_alarm_report = p_report;
        o_result.clear_vibration    = p_vib;
        o_result.theft_check        = n_st.theft_check_flag;
    end

endmodule

`default_nettype wire

/* rtl/tracker_power_mode_controller.sv */
// ----------------------------------------------------------------------------
// tracker_power_mode_controller
// Power mode selection (active, standby, sleep) from time-stamped events.
// ----------------------------------------------------------------------------
// The block takes one event item per clock cycle while the output side does not
// stall, and returns one result item for each. An accepted item sits in the
// input register while the combinational state update runs, and its result is
// registered into the output register as the item advances, which a held,
// stalled result can delay. The output register lets a new item enter while a
// result waits; input stall rises only when both registers are full and the
// output side stalls. Configuration registers are written through a plain write
// port; the user must write them only while no item is in flight, which the
// block itself does not enforce.
`default_nettype none

module tracker_power_mode_controller (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire tpmc_pkg::t_in_item               i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output tpmc_pkg::t_out_item                   o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [tpmc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tpmc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    tpmc_pkg::t_cfg      cfg;
    tpmc_pkg::t_state    r_state;
    tpmc_pkg::t_state    n_state;
    tpmc_pkg::t_in_item  r_item;
    tpmc_pkg::t_out_item n_result;
    tpmc_pkg::t_out_item r_result;
    logic                r_item_valid;
    logic                r_out_valid;
    logic                item_adv;
    logic                in_acc;

    tpmc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tpmc_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Handshake: item moves on unless a result is held against a stall
    assign item_adv   = r_item_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_item_valid && r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
    end

    // Controller state, updated as the item passes to the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.current_mode         <= tpmc_pkg::MODE_ACTIVE;
            r_state.ignition_state       <= 1'b0;
            r_state.ignition_off_pending <= 1'b0;
            r_state.ignition_off_time    <= '0;
            r_state.motion_state         <= 1'b0;
            r_state.motion_time          <= '0;
            r_state.vibration_alarm      <= 1'b0;
            r_state.theft_check_flag     <= 1'b0;
        end else if (item_adv) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (item_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_adv) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_result;

    // Checks
    a_change_saves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.mode_changed |-> r_result.save_request)
        else $error("mode change without save request");

    a_gps_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.gps_power ==
                         (r_result.track_mode != tpmc_pkg::MODE_SLEEP)))
        else $error("gps power disagrees with mode");

    a_clear_vib_sleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.clear_vibration |->
            r_result.track_mode == tpmc_pkg::MODE_SLEEP && !r_result.moving)
        else $error("vibration clear outside entry to sleep");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_adv |=> r_out_valid)
        else $error("advanced item produced no result");

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Event-driven test of the tracker power mode controller.
// ----------------------------------------------------------------------------
// An initial block walks through configuration phases. Each phase fills a
// queue of event items. A clocked driver offers them on the input channel,
// and a clocked stall process throttles the result channel. At every accepted
// event item, a local mode tracker predicts the result item. Each result item
// is checked field by field against the oldest prediction. The phases cover
// directed corner events, random event streams with drifting, backward and
// wrapping timestamps, long output stalls and drained bursts.

module testbench;
    import tpmc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_OFF_LEN  = 80;
    localparam int REPORT_CAP    = 50;

    // DUT connections
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Stimulus and scoreboard storage
    t_in_item  pending_events[$];
    t_out_item predicted_results[$];

    // Mode tracker state and its copy of the registers
    t_state trk;
    t_cfg   cfg;
    logic   p_changed, p_save, p_report, p_vib;

    // Traffic knobs set per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requested = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    logic        in_took     = 1'b0;
    logic [31:0] clock_sec   = '0;
    int          step_max    = 4;
    int          cycle_count = 0;
    int          mismatch_count = 0;
    int          events_sent = 0;
    int          results_checked = 0;
    int          phase_count = 0;

    tracker_power_mode_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Mode tracker
    // ------------------------------------------------------------------------
    function automatic void go_mode(logic [1:0] m);
        if (trk.current_mode != m) begin
            trk.current_mode = m;
            p_save = 1'b1;
            p_changed = 1'b1;
        end
    endfunction

    function automatic void wake_at(logic [TIME_W-1:0] t);
        trk.motion_time = t;
        trk.motion_state = 1'b1;
    endfunction

    function automatic void ignition_on_at(logic [TIME_W-1:0] t);
        wake_at(t);
        trk.ignition_state = 1'b1;
        trk.ignition_off_pending = 1'b0;
        trk.theft_check_flag = 1'b0;
    endfunction

    function automatic void ignition_off_at(logic [TIME_W-1:0] t);
        wake_at(t);
        trk.ignition_off_time = t;
        trk.ignition_off_pending = 1'b1;
        trk.ignition_state = 1'b0;
        if (!cfg.anti_theft_enable)
            trk.theft_check_flag = 1'b1;
    endfunction

    function automatic void periodic_check(logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] since;
        // motion timeout, with a backward clock pulling the mark to now
        if (trk.motion_state) begin
            since = t - trk.motion_time;
            if (t < trk.motion_time) begin
                trk.motion_time = t;
            end else if (since >= TIME_W'(cfg.sleep_delay_sec)) begin
                trk.motion_time = t;
                trk.motion_state = 1'b0;
                p_save = 1'b1;
            end
        end
        // alarm hold, modular elapsed time
        since = t - trk.motion_time;
        if (trk.vibration_alarm && since >= TIME_W'(cfg.alarm_hold_sec)) begin
            trk.vibration_alarm = 1'b0;
            p_save = 1'b1;
        end
        // mode selection
        if (trk.ignition_state) begin
            go_mode(MODE_ACTIVE);
        end else if (!cfg.sleep_enable) begin
            go_mode(MODE_STANDBY);
        end else if (trk.ignition_off_pending) begin
            if (trk.current_mode != MODE_STANDBY && trk.current_mode != MODE_SLEEP)
                go_mode(MODE_STANDBY);
            if (t > trk.ignition_off_time) begin
                since = t - trk.ignition_off_time;
                if (since >= TIME_W'(cfg.sleep_delay_sec)) begin
                    trk.ignition_off_pending = 1'b0;
                    go_mode(MODE_SLEEP);
                end
            end else begin
                trk.ignition_off_time = t;
            end
        end else if (trk.motion_state) begin
            go_mode(MODE_STANDBY);
        end else begin
            go_mode(MODE_SLEEP);
        end
    endfunction

    function automatic void run_command(logic [1:0] target, logic [TIME_W-1:0] t);
        case (target)
            MODE_ACTIVE: begin
                if (trk.current_mode != MODE_ACTIVE) begin
                    ignition_on_at(t);
                    p_report = 1'b1;
                    go_mode(MODE_ACTIVE);
                end
            end
            MODE_STANDBY: begin
                if (trk.current_mode != MODE_STANDBY) begin
                    ignition_off_at(t);
                    p_report = 1'b1;
                    go_mode(MODE_STANDBY);
                end
            end
            MODE_SLEEP: begin
                if (trk.current_mode != MODE_SLEEP) begin
                    if (trk.ignition_state) begin
                        trk.ignition_state = 1'b0;
                        p_report = 1'b1;
                    end
                    trk.motion_time = '0;
                    trk.motion_state = 1'b0;
                    trk.ignition_off_time = '0;
                    trk.ignition_off_pending = 1'b0;
                    p_vib = 1'b1;
                    go_mode(MODE_SLEEP);
                end
            end
            MODE_IGNORED: begin
                // no effect
            end
        endcase
    endfunction

    function automatic t_out_item predict_event(t_in_item ev);
        t_out_item r;
        p_changed = 1'b0;
        p_save = 1'b0;
        p_report = 1'b0;
        p_vib = 1'b0;
        case (ev.mode)
            EV_PERIODIC: periodic_check(ev.now_sec);
            EV_MOTION: begin
                wake_at(ev.now_sec);
                if (ev.raise_alarm)
                    trk.vibration_alarm = 1'b1;
            end
            EV_COMMAND: run_command(ev.target_mode, ev.now_sec);
            EV_IGNITION: begin
                if (ev.ignition_on != trk.ignition_state) begin
                    if (ev.ignition_on)
                        ignition_on_at(ev.now_sec);
                    else
                        ignition_off_at(ev.now_sec);
                end
            end
        endcase
        r.track_mode         = trk.current_mode;
        r.gps_power          = (trk.current_mode != MODE_SLEEP);
        r.moving             = trk.motion_state;
        r.alarm_active       = trk.vibration_alarm;
        r.mode_changed       = p_changed;
        r.save_request       = p_save;
        r.clear_alarm_report = p_report;
        r.clear_vibration    = p_vib;
        r.theft_check        = trk.theft_check_flag;
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: new item only after the previous one was taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_events.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stall: long hold-off on request, random otherwise
    always @(negedge i_clk) begin
        if (hold_served != hold_requested) begin
            hold_served = hold_requested;
            hold_left = HOLD_OFF_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on accept, check on result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor_blk
        logic      fire;
        t_out_item want;
        fire = i_rst_n && i_in_valid && !o_in_stall;
        if (fire) begin
            predicted_results.push_back(predict_event(i_in_data));
            events_sent++;
        end
        in_took <= fire;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (predicted_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $display("%0t: result with no prediction pending, actual %h",
                             $time, o_out_data);
            end else begin
                want = predicted_results.pop_front();
                check_field("track_mode", want.track_mode, o_out_data.track_mode);
                check_field("gps_power", want.gps_power, o_out_data.gps_power);
                check_field("moving", want.moving, o_out_data.moving);
                check_field("alarm_active", want.alarm_active, o_out_data.alarm_active);
                check_field("mode_changed", want.mode_changed, o_out_data.mode_changed);
                check_field("save_request", want.save_request, o_out_data.save_request);
                check_field("clear_alarm_report", want.clear_alarm_report,
                            o_out_data.clear_alarm_report);
                check_field("clear_vibration", want.clear_vibration,
                            o_out_data.clear_vibration);
                check_field("theft_check", want.theft_check, o_out_data.theft_check);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_SLEEP_DELAY: cfg.sleep_delay_sec   = data[DELAY_W-1:0];
            CFG_SLEEP_EN:    cfg.sleep_enable      = data[0];
            CFG_ANTI_THEFT:  cfg.anti_theft_enable = data[0];
            CFG_ALARM_HOLD:  cfg.alarm_hold_sec    = data[HOLD_W-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(int delay, int en, int anti, int hold);
        write_reg(CFG_SLEEP_DELAY, CFG_DATA_W'(delay));
        write_reg(CFG_SLEEP_EN, CFG_DATA_W'(en));
        write_reg(CFG_ANTI_THEFT, CFG_DATA_W'(anti));
        write_reg(CFG_ALARM_HOLD, CFG_DATA_W'(hold));
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || i_in_valid || predicted_results.size() != 0)
            @(posedge i_clk);
    endtask

    // drain, let the pipeline settle, then set traffic for the next phase
    task automatic next_phase(int idle_pct, int stall_pct, int steps);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        step_max       = steps;
        phase_count++;
    endtask

    task automatic queue_event(logic [1:0] kind, logic [31:0] t, logic [1:0] target,
                               logic ign, logic alarm);
        t_in_item ev;
        ev.mode        = kind;
        ev.now_sec     = t;
        ev.target_mode = target;
        ev.ignition_on = ign;
        ev.raise_alarm = alarm;
        pending_events.push_back(ev);
    endtask

    task automatic queue_random(int count);
        t_in_item ev;
        int       roll;
        repeat (count) begin
            // time mostly drifts forward; sometimes runs back, jumps or wraps
            roll = $urandom_range(99);
            if (roll < 3)
                clock_sec = clock_sec - $urandom_range(4 * step_max + 1);
            else if (roll < 5)
                clock_sec = $urandom;
            else if (roll < 6)
                clock_sec = 32'hFFFF_FFFF - $urandom_range(4 * step_max);
            else
                clock_sec = clock_sec + $urandom_range(step_max);
            ev.now_sec     = clock_sec;
            ev.target_mode = 2'($urandom_range(3));
            ev.ignition_on = 1'($urandom_range(1));
            ev.raise_alarm = 1'($urandom_range(1));
            roll = $urandom_range(99);
            if (roll < 45)
                ev.mode = EV_PERIODIC;
            else if (roll < 63)
                ev.mode = EV_MOTION;
            else if (roll < 83)
                ev.mode = EV_COMMAND;
            else
                ev.mode = EV_IGNITION;
            pending_events.push_back(ev);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        trk = '0;
        trk.current_mode = MODE_ACTIVE;
        cfg.sleep_delay_sec   = SLEEP_DELAY_RST;
        cfg.sleep_enable      = 1'b1;
        cfg.anti_theft_enable = 1'b0;
        cfg.alarm_hold_sec    = ALARM_HOLD_RST;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed events under reset register values
        phase_count++;
        queue_event(EV_PERIODIC, 32'd0, MODE_ACTIVE, 1'b0, 1'b0);
        queue_event(EV_IGNITION, 32'd5, MODE_ACTIVE, 1'b0, 1'b0);   // same level
        queue_event(EV_MOTION, 32'd10, MODE_ACTIVE, 1'b0, 1'b1);
        queue_event(EV_PERIODIC, 32'd20, MODE_ACTIVE, 1'b0, 1'b0);
        queue_event(EV_COMMAND, 32'd30, MODE_ACTIVE, 1'b0, 1'b0);
        queue_event(EV_COMMAND, 32'd31, MODE_ACTIVE, 1'b0, 1'b0);   // already active
        queue_event(EV_IGNITION, 32'd32, MODE_ACTIVE, 1'b1, 1'b0);  // already on
        queue_event(EV_PERIODIC, 32'd40, MODE_ACTIVE, 1'b0, 1'b0);
        queue_event(EV_IGNITION, 32'd50, MODE_ACTIVE, 1'b0, 1'b0);
        queue_event(EV_PERIODIC, 32'd60, MODE_ACTIVE, 1'b0, 1'b0);
        queue_event(EV_PERIODIC, 32'd400, MODE_ACTIVE, 1'b0, 1'b0); // still and sleep
        queue_event(EV_PERIODIC, 32'd800, MODE_ACTIVE, 1'b0, 1'b0); // alarm clears
        queue_event(EV_COMMAND, 32'd810, MODE_STANDBY, 1'b0, 1'b0);
        queue_event(EV_COMMAND, 32'd820, MODE_IGNORED, 1'b1, 1'b1);
        queue_event(EV_COMMAND, 32'd830, MODE_SLEEP, 1'b0, 1'b0);
        queue_event(EV_COMMAND, 32'd840, MODE_ACTIVE, 1'b0, 1'b0);
        queue_event(EV_COMMAND, 32'd850, MODE_SLEEP, 1'b0, 1'b0);   // ignition was on
        queue_event(EV_MOTION, 32'hFFFF_FFF0, MODE_ACTIVE, 1'b0, 1'b1);
        queue_event(EV_PERIODIC, 32'h0000_0010, MODE_ACTIVE, 1'b0, 1'b0); // clock back
        queue_event(EV_PERIODIC, 32'h0000_0400, MODE_ACTIVE, 1'b0, 1'b0);
        queue_event(EV_PERIODIC, 32'h0000_0005, MODE_ACTIVE, 1'b0, 1'b0); // alarm wraps
        queue_event(EV_COMMAND, 32'hFFFF_FFFF, MODE_STANDBY, 1'b0, 1'b0);
        queue_event(EV_PERIODIC, 32'h0000_0003, MODE_ACTIVE, 1'b0, 1'b0); // off time back
        queue_event(EV_PERIODIC, 32'hFFFF_FFFF, MODE_IGNORED, 1'b1, 1'b1);
        queue_event(EV_IGNITION, 32'h0000_0000, MODE_SLEEP, 1'b1, 1'b1);

        // Short delays, no idling
        next_phase(0, 0, 3);
        configure(5, 1, 0, 8);
        queue_random(400);

        // Zero delays, sleep disabled, anti-theft armed, sender idles
        next_phase(45, 0, 3);
        configure(0, 0, 1, 0);
        queue_random(300);

        // Long sleep delay, largest alarm hold, receiver stalls
        next_phase(0, 45, 20000);
        configure(86400, 1, 0, 65535);
        queue_random(300);

        // Mid delays, both sides idle
        next_phase(22, 22, 8);
        configure(20, 1, 1, 10);
        queue_random(400);

        // Long output hold-off while the sender keeps offering, then bursts
        next_phase(0, 0, 6);
        configure(12, 1, 0, 30);
        queue_random(150);
        hold_requested++;
        wait_drained();
        repeat (10) begin
            queue_random(15);
            wait_drained();
        end
        queue_random(100);
        hold_requested++;

        // Data wider than the register is cut to its width
        next_phase(22, 22, 5);
        write_reg(CFG_SLEEP_DELAY, 17'd7);
        write_reg(CFG_SLEEP_EN, 17'h1_0001);
        write_reg(CFG_ANTI_THEFT, 17'h1_FFFE);
        write_reg(CFG_ALARM_HOLD, 17'h1_0009);
        queue_random(300);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d events in %0d register settings, %0d results compared,",
                 events_sent, phase_count, results_checked);
        $display("with idle, stall and hold-off traffic; %0d mismatches, %0d left over",
                 mismatch_count, predicted_results.size());
        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* tracker_power_mode_controller.f */
rtl/tpmc_pkg.sv
rtl/tpmc_cfg_regs.sv
rtl/tpmc_step.sv
rtl/tracker_power_mode_controller.sv
dv/testbench.sv
